// ===== src/lota_pkg.sv =====
// Shared types and constants for the LoRa time-on-air pipeline.
package lota_pkg;

  // Stage counts: decode, symbol-count divider, three count/multiply/shift stages
  localparam int unsigned SDIV_STEPS   = 12;
  localparam int unsigned FRONT_STAGES = SDIV_STEPS + 4;
  localparam int unsigned BDIV_STEPS   = 36;

  localparam logic [15:0] PREAMBLE_RESET = 16'd8;
  localparam logic [19:0] US_PER_S       = 20'd1000000;
  localparam logic [4:0]  SYNC_QUARTERS  = 5'd17;
  localparam logic [11:0] COUNT_MAX      = 12'hFFF;
  localparam logic [35:0] AIRTIME_MAX    = 36'hFFFFFFFFF;

  typedef struct packed {
    logic [7:0]  payload_bytes;
    logic [3:0]  spreading_factor;
    logic [18:0] bandwidth_hz;
    logic [2:0]  coding_rate;
    logic        crc_on;
    logic        implicit_header;
    logic        low_rate_opt;
  } lota_in_t;

  typedef struct packed {
    logic [11:0] payload_symbol_count;
    logic [35:0] airtime_us;
  } lota_out_t;

  // Operands entering the airtime divider
  typedef struct packed {
    logic [20:0] rem;
    logic [35:0] dq;
    logic [20:0] dvs;
    logic        sat;
    logic [11:0] count;
  } lota_div_in_t;

  // Quotient leaving the airtime divider
  typedef struct packed {
    logic [35:0] quot;
    logic        sat;
    logic [11:0] count;
  } lota_div_out_t;

endpackage

// ===== src/lora_time_on_air_top.sv =====
// LoRa time-on-air calculator: payload symbol count and airtime per transfer.
//
//  channel | dir | payload    | transfer when
//  cfg     | in  | 16b        | cfg_valid_i && cfg_ready_o (always ready)
//  in      | in  | lota_in_t  | in_valid_i && in_ready_o
//  out     | out | lota_out_t | out_valid_o && out_ready_i
//
// One item per cycle while the output is not stalled. Stages: decode, 12 stages of the
// symbol-count divider, count/multiply/shift stages, 36 stages of the airtime divider,
// and the output register. Reset empties all stages and sets the preamble to 8.
// A stall holds each occupied stage; empty stages ahead keep filling.
module lora_time_on_air_top import lota_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cfg_valid_i,
  output logic      cfg_ready_o,
  input  logic [15:0] cfg_data_i,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  lota_in_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output lota_out_t out_data_o
);

  localparam int unsigned NF = FRONT_STAGES;
  localparam int unsigned NS = SDIV_STEPS;

  logic [15:0]   preamble_q;
  logic [NF-1:0] v_q;
  logic [NF:0]   adv;
  logic          div_in_ready;
  logic          div_out_valid;
  lota_div_out_t div_out;
  logic          ov_q;
  lota_out_t     out_q;
  logic          adv_out;

  // Symbol-count divider stages (index 0 is the decode stage)
  logic [5:0]  sd_rem_q [NS+1];
  logic [11:0] sd_dq_q  [NS+1];
  logic [5:0]  sd_den_q [NS+1];
  lota_in_t    x_q      [NS+1];
  logic [5:0]  sd_rem_d [NS+1];
  logic [11:0] sd_dq_d  [NS+1];
  logic [5:0]  sd_den_d [NS+1];

  // Count, multiply and shift stages
  logic [18:0]  m1_quarters_q, m1_quarters_d;
  logic [11:0]  m1_cnt_q, m1_cnt_d;
  logic [3:0]   m1_sf_q;
  logic [18:0]  m1_bw_q;
  logic [38:0]  m2_prod_q;
  logic [11:0]  m2_cnt_q;
  logic [3:0]   m2_sf_q;
  logic [18:0]  m2_bw_q;
  lota_div_in_t d3_q, d3_d;

  // Configuration register
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      preamble_q <= PREAMBLE_RESET;
    end else if (cfg_valid_i) begin
      preamble_q <= cfg_data_i;
    end
  end

  // Ready chain through the front stages
  always_comb begin
    adv[NF] = div_in_ready;
    for (int k = NF - 1; k >= 0; k--) begin
      adv[k] = !v_q[k] || adv[k+1];
    end
  end
  assign in_ready_o = adv[0];

  // Decode: ceil numerator and denominator
  always_comb begin
    logic signed [12:0] num;
    logic [3:0]         sfe;
    logic               pos_den;
    logic               use_blk;
    logic [5:0]         den6;
    num = $signed({2'b00, in_data_i.payload_bytes, 3'b000}) + 13'sd28
        + (in_data_i.crc_on ? 13'sd16 : 13'sd0)
        - $signed({7'b0, in_data_i.spreading_factor, 2'b00})
        - (in_data_i.implicit_header ? 13'sd20 : 13'sd0);
    sfe     = in_data_i.spreading_factor - {2'b00, in_data_i.low_rate_opt, 1'b0};
    pos_den = in_data_i.low_rate_opt ? (in_data_i.spreading_factor > 4'd2)
                                     : (in_data_i.spreading_factor != 4'd0);
    use_blk = pos_den && (num > 13'sd0);
    den6    = {sfe, 2'b00};
    sd_rem_d[0] = '0;
    sd_dq_d[0]  = use_blk ? (num[11:0] + {6'b0, den6} - 12'd1) : 12'd0;
    sd_den_d[0] = use_blk ? den6 : 6'd4;
  end

  // Restoring division steps for the block count
  always_comb begin
    logic [6:0] part;
    logic [6:0] diff;
    logic       ge;
    for (int k = 1; k <= NS; k++) begin
      part = {sd_rem_q[k-1], sd_dq_q[k-1][11]};
      diff = part - {1'b0, sd_den_q[k-1]};
      ge   = part >= {1'b0, sd_den_q[k-1]};
      sd_rem_d[k] = ge ? diff[5:0] : part[5:0];
      sd_dq_d[k]  = {sd_dq_q[k-1][10:0], ge};
      sd_den_d[k] = sd_den_q[k-1];
    end
  end

  // Symbol count and quarter-symbol total
  always_comb begin
    logic [3:0]  cr4;
    logic [15:0] prod;
    logic [15:0] cnt16;
    logic [12:0] cnt13;
    cr4   = {1'b0, x_q[NS].coding_rate} + 4'd4;
    prod  = {4'b0, sd_dq_q[NS]} * {12'b0, cr4};
    cnt16 = prod + 16'd8;
    cnt13 = cnt16[12:0];
    m1_cnt_d      = (cnt13 > {1'b0, COUNT_MAX}) ? COUNT_MAX : cnt13[11:0];
    m1_quarters_d = {1'b0, preamble_q, 2'b00} + {14'b0, SYNC_QUARTERS}
                  + {4'b0, cnt13, 2'b00};
  end

  // Chip scaling, divisor and overflow check
  always_comb begin
    logic [53:0] shifted;
    logic [20:0] dvs;
    shifted  = {15'b0, m2_prod_q} << m2_sf_q;
    dvs      = {m2_bw_q, 2'b00};
    d3_d.rem   = {3'b000, shifted[53:36]};
    d3_d.dq    = shifted[35:0];
    d3_d.dvs   = dvs;
    d3_d.sat   = (m2_bw_q == 19'd0) || ({3'b000, shifted[53:36]} >= dvs);
    d3_d.count = m2_cnt_q;
  end

  // Valid bits of the front stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (adv[0]) v_q[0] <= in_valid_i;
      for (int k = 1; k < NF; k++) begin
        if (adv[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  // Front stage data
  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      sd_rem_q[0] <= sd_rem_d[0];
      sd_dq_q[0]  <= sd_dq_d[0];
      sd_den_q[0] <= sd_den_d[0];
      x_q[0]      <= in_data_i;
    end
    for (int k = 1; k <= NS; k++) begin
      if (adv[k]) begin
        sd_rem_q[k] <= sd_rem_d[k];
        sd_dq_q[k]  <= sd_dq_d[k];
        sd_den_q[k] <= sd_den_d[k];
        x_q[k]      <= x_q[k-1];
      end
    end
    if (adv[NS+1]) begin
      m1_quarters_q <= m1_quarters_d;
      m1_cnt_q      <= m1_cnt_d;
      m1_sf_q       <= x_q[NS].spreading_factor;
      m1_bw_q       <= x_q[NS].bandwidth_hz;
    end
    if (adv[NS+2]) begin
      m2_prod_q <= {20'b0, m1_quarters_q} * {19'b0, US_PER_S};
      m2_cnt_q  <= m1_cnt_q;
      m2_sf_q   <= m1_sf_q;
      m2_bw_q   <= m1_bw_q;
    end
    if (adv[NS+3]) begin
      d3_q <= d3_d;
    end
  end

  lota_airdiv u_airdiv (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (v_q[NF-1]),
    .in_ready_o  (div_in_ready),
    .in_data_i   (d3_q),
    .out_valid_o (div_out_valid),
    .out_ready_i (adv_out),
    .out_data_o  (div_out)
  );

  // Output register
  assign adv_out = !ov_q || out_ready_i;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (adv_out) begin
      ov_q <= div_out_valid;
    end
  end
  always_ff @(posedge clk_i) begin
    if (adv_out) begin
      out_q.payload_symbol_count <= div_out.count;
      out_q.airtime_us           <= div_out.sat ? AIRTIME_MAX : div_out.quot;
    end
  end

  assign out_valid_o = ov_q;
  assign out_data_o  = out_q;

  // Block-count remainder is below the denominator after the last step
  a_sd_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[NS] |-> (sd_rem_q[NS] < sd_den_q[NS]))
    else $error("block count remainder out of range");

  // Every result carries at least the header symbols
  a_min_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.payload_symbol_count >= 12'd8))
    else $error("symbol count below header length");

  // Input backpressure only with an occupied decode stage
  a_in_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> v_q[0])
    else $error("input stalled with empty decode stage");

  // A front item blocked by the divider stays put
  a_front_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_q[NF-1] && !div_in_ready) |=> v_q[NF-1])
    else $error("front item lost while divider stalled");

endmodule

// ===== src/lota_airdiv.sv =====
// Pipelined restoring divider for the airtime, one quotient bit per stage.
module lota_airdiv import lota_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  lota_div_in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output lota_div_out_t out_data_o
);

  logic [BDIV_STEPS-1:0] v_q;
  logic [BDIV_STEPS:0]   adv;
  logic [20:0] rem_q [BDIV_STEPS];
  logic [35:0] dq_q  [BDIV_STEPS];
  logic [20:0] dvs_q [BDIV_STEPS];
  logic        sat_q [BDIV_STEPS];
  logic [11:0] cnt_q [BDIV_STEPS];
  logic [20:0] rem_d [BDIV_STEPS];
  logic [35:0] dq_d  [BDIV_STEPS];

  // A stage may load when it is empty or its content moves on
  always_comb begin
    adv[BDIV_STEPS] = out_ready_i;
    for (int k = BDIV_STEPS - 1; k >= 0; k--) begin
      adv[k] = !v_q[k] || adv[k+1];
    end
  end

  // One compare-and-subtract per stage
  always_comb begin
    logic [21:0] part;
    logic        ge;
    logic [21:0] diff;
    for (int k = 0; k < BDIV_STEPS; k++) begin
      if (k == 0) begin
        part = {in_data_i.rem, in_data_i.dq[35]};
        diff = part - {1'b0, in_data_i.dvs};
        ge   = part >= {1'b0, in_data_i.dvs};
        dq_d[k] = {in_data_i.dq[34:0], ge};
      end else begin
        part = {rem_q[k-1], dq_q[k-1][35]};
        diff = part - {1'b0, dvs_q[k-1]};
        ge   = part >= {1'b0, dvs_q[k-1]};
        dq_d[k] = {dq_q[k-1][34:0], ge};
      end
      rem_d[k] = ge ? diff[20:0] : part[20:0];
    end
  end

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (adv[0]) v_q[0] <= in_valid_i;
      for (int k = 1; k < BDIV_STEPS; k++) begin
        if (adv[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  // Stage data
  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      rem_q[0] <= rem_d[0];
      dq_q[0]  <= dq_d[0];
      dvs_q[0] <= in_data_i.dvs;
      sat_q[0] <= in_data_i.sat;
      cnt_q[0] <= in_data_i.count;
    end
    for (int k = 1; k < BDIV_STEPS; k++) begin
      if (adv[k]) begin
        rem_q[k] <= rem_d[k];
        dq_q[k]  <= dq_d[k];
        dvs_q[k] <= dvs_q[k-1];
        sat_q[k] <= sat_q[k-1];
        cnt_q[k] <= cnt_q[k-1];
      end
    end
  end

  assign in_ready_o       = adv[0];
  assign out_valid_o      = v_q[BDIV_STEPS-1];
  assign out_data_o.quot  = dq_q[BDIV_STEPS-1];
  assign out_data_o.sat   = sat_q[BDIV_STEPS-1];
  assign out_data_o.count = cnt_q[BDIV_STEPS-1];

  // Partial remainder stays below the divisor when not saturated
  a_rem_below: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_data_o.sat) |-> (rem_q[BDIV_STEPS-1] < dvs_q[BDIV_STEPS-1]))
    else $error("divider remainder out of range");

  // A stalled result holds its quotient
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(out_data_o)))
    else $error("divider result changed while stalled");

  // Backpressure only when the first stage is occupied
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> v_q[0])
    else $error("divider stalls with empty first stage");

endmodule

// ===== tb/sv/lora_time_on_air_checker.sv =====
// Checker for the LoRa time-on-air block: watches all channels, predicts and compares results.
`timescale 1ns / 100ps
module lora_time_on_air_checker import lota_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  lota_in_t    in_data_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  lota_out_t   out_data_i,
  output int          errors_o,
  output int          pending_o
);

  logic [15:0] preamble_q;
  lota_out_t   airtime_q[$];

  // Symbol count and airtime in microseconds of one transmission
  function automatic lota_out_t predict_airtime(lota_in_t it, logic [15:0] preamble);
    longint    num;
    longint    den;
    longint    blocks;
    longint    count;
    longint    quarters;
    longint    numer;
    longint    air;
    lota_out_t res;
    num = 8 * longint'(it.payload_bytes) - 4 * longint'(it.spreading_factor) + 28
          + 16 * longint'(it.crc_on) - 20 * longint'(it.implicit_header);
    den = 4 * (longint'(it.spreading_factor) - 2 * longint'(it.low_rate_opt));
    blocks = 0;
    if (num > 0 && den > 0) blocks = (num + den - 1) / den;
    count = 8 + blocks * (longint'(it.coding_rate) + 4);
    if (it.bandwidth_hz == 0) begin
      air = longint'(AIRTIME_MAX);
    end else begin
      quarters = 4 * longint'(preamble) + 17 + 4 * count;
      numer = (quarters << it.spreading_factor) * 1000000;
      air = numer / (4 * longint'(it.bandwidth_hz));
      if (air > longint'(AIRTIME_MAX)) air = longint'(AIRTIME_MAX);
    end
    res.payload_symbol_count = (count > 4095) ? 12'hFFF : count[11:0];
    res.airtime_us = air[35:0];
    return res;
  endfunction

  assign pending_o = airtime_q.size();

  // Track register, queue predictions, compare each result transfer
  always @(posedge clk_i or negedge rst_ni) begin
    lota_out_t exp_r;
    if (!rst_ni) begin
      preamble_q = PREAMBLE_RESET;
      airtime_q.delete();
      errors_o = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (airtime_q.size() == 0) begin
          errors_o++;
          if (errors_o <= 10) $display("unexpected result transfer: %p", out_data_i);
        end else begin
          exp_r = airtime_q.pop_front();
          if (exp_r.payload_symbol_count !== out_data_i.payload_symbol_count ||
              exp_r.airtime_us !== out_data_i.airtime_us) begin
            errors_o++;
            if (errors_o <= 10)
              $display("mismatch: count exp %0d got %0d, airtime exp %0d got %0d",
                       exp_r.payload_symbol_count, out_data_i.payload_symbol_count,
                       exp_r.airtime_us, out_data_i.airtime_us);
          end
        end
      end
      if (in_valid_i && in_ready_i) airtime_q.push_back(predict_airtime(in_data_i, preamble_q));
      if (cfg_valid_i && cfg_ready_i) preamble_q = cfg_data_i;
    end
  end

endmodule

// ===== tb/sv/lora_time_on_air_top_tb.sv =====
// Testbench top for the LoRa time-on-air block: stimulus, flow control and verdict.
`timescale 1ns / 100ps
module lora_time_on_air_top_tb;
  import lota_pkg::*;

  localparam int DRAIN_CYCLES = 60;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  lota_in_t    in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  lota_out_t   out_data;
  int          errors;
  int          pending;
  bit          quiet = 1'b0;
  bit          stall_req = 1'b0;
  bit          stall_seen = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  lora_time_on_air_top i_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_data_i (cfg_data),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data)
  );

  lora_time_on_air_checker i_checker (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_i(cfg_ready),
    .cfg_data_i (cfg_data),
    .in_valid_i (in_valid),
    .in_ready_i (in_ready),
    .in_data_i  (in_data),
    .out_valid_i(out_valid),
    .out_ready_i(out_ready),
    .out_data_i (out_data),
    .errors_o   (errors),
    .pending_o  (pending)
  );

  // Generous overall limit
  initial begin
    #5ms;
    $display("DONE: errors detected");
    $finish;
  end

  // Receiver: random stall bursts, one long hold-off on request
  initial begin
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (stall_req && !stall_seen) begin
        stall_seen = 1'b1;
        out_ready <= 1'b0;
        repeat (400) @(posedge clk);
      end else if (!quiet && $urandom_range(4) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // One transmission transfer, then maybe an idle burst
  task automatic send_plan(input lota_in_t it);
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    if (!quiet && $urandom_range(3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
  endtask

  task automatic send_fields(input int pl, input int sf, input int bw, input int cr,
                             input int crc, input int hdr, input int de);
    lota_in_t it;
    it.payload_bytes    = pl[7:0];
    it.spreading_factor = sf[3:0];
    it.bandwidth_hz     = bw[18:0];
    it.coding_rate      = cr[2:0];
    it.crc_on           = crc[0];
    it.implicit_header  = hdr[0];
    it.low_rate_opt     = de[0];
    send_plan(it);
  endtask

  // Stop offering, wait out all results and the pipeline latency
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_preamble(input logic [15:0] v);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // Mostly legal plans, some outside the documented ranges
  function automatic lota_in_t random_plan();
    logic [63:0] raw;
    lota_in_t    it;
    raw = {$urandom, $urandom};
    it  = raw[$bits(lota_in_t)-1:0];
    if ($urandom_range(7) != 0) it.spreading_factor = 4'($urandom_range(6, 12));
    case ($urandom_range(9))
      0:       it.bandwidth_hz = '0;
      1:       it.bandwidth_hz = 19'($urandom_range(1, 'h7FFFF));
      default: it.bandwidth_hz = 19'($urandom_range(7800, 500000));
    endcase
    if ($urandom_range(7) != 0) it.coding_rate = 3'($urandom_range(1, 4));
    return it;
  endfunction

  task automatic random_phase(input int n, input bit with_stall);
    for (int i = 0; i < n; i++) begin
      if (with_stall && i == n / 2) stall_req = 1'b1;
      send_plan(random_plan());
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: field extremes and special cases at reset preamble, then at other preambles
    send_fields(0, 6, 7800, 1, 0, 0, 0);
    send_fields(255, 12, 500000, 4, 1, 0, 0);
    send_fields(255, 12, 7800, 4, 1, 0, 1);
    send_fields(0, 12, 125000, 1, 0, 1, 0);
    send_fields(1, 7, 250000, 2, 0, 1, 1);
    send_fields(10, 2, 125000, 1, 0, 0, 1);
    send_fields(10, 0, 125000, 1, 0, 0, 0);
    send_fields(50, 8, 125000, 0, 1, 0, 0);
    send_fields(50, 8, 125000, 7, 1, 1, 0);
    send_fields(255, 1, 125000, 7, 1, 0, 0);
    send_fields(100, 9, 0, 3, 0, 0, 0);
    send_fields(255, 15, 1, 7, 1, 0, 0);
    send_fields(128, 10, 'h7FFFF, 4, 1, 1, 1);
    send_fields(255, 15, 'h7FFFF, 7, 1, 1, 1);
    write_preamble(16'd6);
    send_fields(20, 7, 125000, 1, 1, 0, 0);
    send_fields(255, 12, 7800, 4, 1, 0, 1);
    write_preamble(16'hFFFF);
    send_fields(255, 12, 7800, 4, 1, 0, 1);
    send_fields(255, 15, 1, 7, 1, 0, 0);
    send_fields(0, 6, 500000, 1, 0, 1, 0);
    write_preamble(16'd0);
    send_fields(0, 6, 500000, 1, 0, 0, 0);

    // Random phases across several preamble settings
    write_preamble(16'($urandom_range(6, 65535)));
    random_phase(400, 1'b1);
    write_preamble(16'd6);
    random_phase(400, 1'b0);
    write_preamble(16'hFFFF);
    random_phase(400, 1'b0);
    write_preamble(16'($urandom));
    quiet = 1'b1;
    random_phase(400, 1'b0);

    drain();
    if (errors == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/lota_pkg.sv
src/lota_airdiv.sv
src/lora_time_on_air_top.sv
tb/sv/lora_time_on_air_checker.sv
tb/sv/lora_time_on_air_top_tb.sv
